/* src/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// Types and character codes shared by the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int unsigned ColBits   = 11;
	localparam int unsigned RowBits   = 10;
	localparam int unsigned CountBits = 10;
	localparam int unsigned ParamBits = 32;

	localparam logic [7:0] CHAR_BS  = 8'h08;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0a;
	localparam logic [7:0] CHAR_CR  = 8'h0d;
	localparam logic [7:0] CHAR_ESC = 8'h1b;
	localparam logic [7:0] CHAR_D0  = 8'h30;
	localparam logic [7:0] CHAR_D9  = 8'h39;
	localparam logic [7:0] CHAR_LEFT = 8'h44;
	localparam logic [7:0] CHAR_LBRACKET = 8'h5b;

	localparam logic [ColBits-1:0]   TAB_STOP = 11'd8;
	localparam logic [RowBits-1:0]   ROW_MAX  = 10'd1023;
	localparam logic [CountBits-1:0] COLUMN_COUNT_RESET = 10'd80;
	localparam logic [CountBits-1:0] ROW_COUNT_RESET    = 10'd25;

	typedef enum logic [0:0] {
		CFG_COLUMN_COUNT = 1'b0,
		CFG_ROW_COUNT    = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [ColBits-1:0]   col;
		logic [RowBits-1:0]   row;
		logic                 esc;
		logic [ParamBits-1:0] param;
	} cursor_state_t;

	typedef struct packed {
		logic                 draw;
		logic [7:0]           glyph;
		logic [CountBits-1:0] draw_col;
		logic [RowBits-1:0]   draw_row;
		logic [1:0]           scroll;
		logic                 inval;
	} step_res_t;

	typedef struct packed {
		cursor_state_t st;
		step_res_t     res;
	} step_t;

endpackage

/* src/text_console_cursor_engine_top.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Character cursor tracker for a text console.
//
// Usage:
//   Input channel (in_valid, in_stall, code) takes one character byte per item.
//   Output channel (out_valid, out_stall, ...) returns exactly one result item
//   per input item: glyph draw request, scroll count, invalidate flag and the
//   cursor position after the character.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
//   column count (index 0) and row count (index 1); cfg_ready is always high.
//   Write configuration only while no item is in flight.
// Timing:
//   An accepted item passes an input register, then the cursor update and the
//   result register, to out_valid. One item per cycle is sustained while
//   out_stall is low; the cursor state feeds back from its own register.
//   While out_stall holds, the result stays put and one more item is taken
//   into the input register before in_stall rises.
// Reset:
//   arst_n clears the cursor, escape mode and parameter, sets 80 columns by
//   25 rows, and empties both registers.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        draw_valid,
	output logic [7:0]  glyph,
	output logic [9:0]  draw_col,
	output logic [9:0]  draw_row,
	output logic [1:0]  scroll_lines,
	output logic        invalidate,
	output logic [9:0]  cursor_col_out,
	output logic [9:0]  cursor_row_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	function automatic logic [tcce_pkg::RowBits-1:0] row_up(
		logic [tcce_pkg::RowBits-1:0] row
	);
		return (row != tcce_pkg::ROW_MAX) ? row + 10'd1 : row;
	endfunction

	function automatic tcce_pkg::step_t handle_char(
		tcce_pkg::cursor_state_t s,
		logic [7:0] c,
		logic [tcce_pkg::CountBits-1:0] cols,
		logic [tcce_pkg::CountBits-1:0] rows
	);
		tcce_pkg::step_t r;
		logic [tcce_pkg::ColBits:0] tab_sum;
		logic draw;
		r.st = s;
		r.res = '0;
		draw = 1'b0;
		tab_sum = {1'b0, s.col} + {1'b0, tcce_pkg::TAB_STOP};
		if (!s.esc) begin
			case (c)
				tcce_pkg::CHAR_CR: r.st.col = '0;
				tcce_pkg::CHAR_LF: begin
					r.st.row = row_up(s.row);
					r.res.inval = 1'b1;
				end
				tcce_pkg::CHAR_BS: begin
					if (s.col != '0) r.st.col = s.col - 11'd1;
				end
				tcce_pkg::CHAR_TAB: r.st.col = {tab_sum[tcce_pkg::ColBits-1:3], 3'b000};
				tcce_pkg::CHAR_ESC: begin
					r.st.param = '0;
					r.st.esc = 1'b1;
				end
				default: draw = 1'b1;
			endcase
		end else begin
			if (c inside {[tcce_pkg::CHAR_D0:tcce_pkg::CHAR_D9]}) begin
				r.st.param = {s.param[28:0], 3'b000} + {s.param[30:0], 1'b0}
					+ {28'd0, c[3:0]};
			end else if (c == tcce_pkg::CHAR_LEFT) begin
				if (s.param <= {21'd0, s.col}) r.st.col = s.col - s.param[10:0];
				r.st.esc = 1'b0;
			end else if (c != tcce_pkg::CHAR_LBRACKET) begin
				draw = 1'b1;
				r.st.esc = 1'b0;
			end
		end
		if (draw) begin
			r.res.draw = 1'b1;
			r.res.glyph = c;
			r.res.draw_col = s.col[9:0];
			r.res.draw_row = s.row;
			r.st.col = s.col + 11'd1;
		end
		if (r.st.col >= {1'b0, cols}) begin
			r.st.col = '0;
			r.st.row = row_up(r.st.row);
			r.res.inval = 1'b1;
		end
		if (r.st.row >= rows) begin
			if (r.st.row != '0) r.st.row = r.st.row - 10'd1;
			r.res.scroll = 2'd1;
			r.res.inval = 1'b1;
		end
		return r;
	endfunction

	logic [tcce_pkg::CountBits-1:0] column_count_q;
	logic [tcce_pkg::CountBits-1:0] row_count_q;
	tcce_pkg::cursor_state_t state_q;
	logic valid_s1;
	logic [7:0] code_s1;
	logic move;
	tcce_pkg::step_t pass_cr;
	tcce_pkg::step_t pass_main;
	tcce_pkg::cursor_state_t state_mid;
	tcce_pkg::step_res_t res_cr;
	tcce_pkg::step_res_t res_next;
	logic is_lf;

	assign cfg_ready = 1'b1;
	assign move      = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= tcce_pkg::COLUMN_COUNT_RESET;
			row_count_q    <= tcce_pkg::ROW_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (tcce_pkg::cfg_index_t'(cfg_index))
				tcce_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				tcce_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) code_s1 <= code;
	end

	// newline runs a carriage return first
	always_comb begin
		is_lf     = (code_s1 == tcce_pkg::CHAR_LF);
		pass_cr   = handle_char(state_q, tcce_pkg::CHAR_CR, column_count_q, row_count_q);
		state_mid = is_lf ? pass_cr.st : state_q;
		res_cr    = is_lf ? pass_cr.res : '0;
		pass_main = handle_char(state_mid, code_s1, column_count_q, row_count_q);
		res_next  = res_cr.draw ? res_cr : pass_main.res;
		res_next.draw     = res_cr.draw | pass_main.res.draw;
		res_next.scroll   = res_cr.scroll + pass_main.res.scroll;
		res_next.inval    = res_cr.inval | pass_main.res.inval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			out_valid <= 1'b0;
		end else if (move) begin
			out_valid <= valid_s1;
			if (valid_s1) state_q <= pass_main.st;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (move && valid_s1) begin
			draw_valid     <= res_next.draw;
			glyph          <= res_next.glyph;
			draw_col       <= res_next.draw_col;
			draw_row       <= res_next.draw_row;
			scroll_lines   <= res_next.scroll;
			invalidate     <= res_next.inval;
			cursor_col_out <= pass_main.st.col[9:0];
			cursor_row_out <= pass_main.st.row;
		end
	end

`ifndef ASSERT_OFF
	a_scroll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> scroll_lines != 2'd3)
		else $error("scroll count out of range");

	a_scroll_inval: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scroll_lines != 2'd0) |-> invalidate)
		else $error("scroll without invalidate");

	a_nodraw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !draw_valid) |-> (glyph == 8'd0 && draw_col == 10'd0
			&& draw_row == 10'd0))
		else $error("draw fields set without a draw");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled with room to advance");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Sends character bytes through the input channel and compares every result
// item field by field against fixed expected values or a cycle-free model of
// the cursor, escape and scroll behavior. It starts with a short directed run
// at reset geometry, then runs random phases over several screen sizes: one
// cell, zero counts, the largest counts, and counts that shrink under the
// cursor. The phases vary their pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic       draw;
		logic [7:0] glyph;
		logic [9:0] dcol;
		logic [9:0] drow;
		logic [1:0] scroll;
		logic       inval;
		logic [9:0] ccol;
		logic [9:0] crow;
	} console_result_t;

	typedef struct packed {
		logic [7:0]      c;
		logic            known;
		console_result_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] code = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       draw_valid;
	logic [7:0] glyph;
	logic [9:0] draw_col;
	logic [9:0] draw_row;
	logic [1:0] scroll_lines;
	logic       invalidate;
	logic [9:0] cursor_col_out;
	logic [9:0] cursor_row_out;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	tcce_pkg::cfg_index_t cfg_index = tcce_pkg::CFG_COLUMN_COUNT;
	logic [9:0] cfg_data = 10'd0;

	logic [tcce_pkg::ColBits-1:0]   cur_col;
	logic [tcce_pkg::RowBits-1:0]   cur_row;
	logic                           cur_esc;
	logic [tcce_pkg::ParamBits-1:0] cur_param;
	logic [tcce_pkg::CountBits-1:0] cols_set;
	logic [tcce_pkg::CountBits-1:0] rows_set;
	console_result_t                step_acc;

	console_result_t pending_results[$];
	logic [7:0]      pending_codes[$];
	stim_row_t       directed_rows[$];

	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	text_console_cursor_engine_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .code(code),
		.out_valid(out_valid), .out_stall(out_stall),
		.draw_valid(draw_valid), .glyph(glyph), .draw_col(draw_col), .draw_row(draw_row),
		.scroll_lines(scroll_lines), .invalidate(invalidate),
		.cursor_col_out(cursor_col_out), .cursor_row_out(cursor_row_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void row_advance();
		if (cur_row < tcce_pkg::ROW_MAX)
			cur_row = cur_row + 1'b1;
	endfunction

	function automatic void draw_at_cursor(input logic [7:0] c);
		step_acc.draw  = 1'b1;
		step_acc.glyph = c;
		step_acc.dcol  = cur_col[9:0];
		step_acc.drow  = cur_row;
		cur_col = cur_col + 1'b1;
	endfunction

	function automatic void apply_char(input logic [7:0] c);
		if (!cur_esc) begin
			if (c == tcce_pkg::CHAR_CR) begin
				cur_col = '0;
			end else if (c == tcce_pkg::CHAR_LF) begin
				row_advance();
				step_acc.inval = 1'b1;
			end else if (c == tcce_pkg::CHAR_BS) begin
				if (cur_col > 0)
					cur_col = cur_col - 1'b1;
			end else if (c == tcce_pkg::CHAR_TAB) begin
				cur_col = (cur_col + tcce_pkg::TAB_STOP) & ~(tcce_pkg::TAB_STOP - 1'b1);
			end else if (c == tcce_pkg::CHAR_ESC) begin
				cur_param = '0;
				cur_esc = 1'b1;
			end else begin
				draw_at_cursor(c);
			end
		end else begin
			if (c >= tcce_pkg::CHAR_D0 && c <= tcce_pkg::CHAR_D9) begin
				cur_param = cur_param * 32'd10 + {24'd0, c - tcce_pkg::CHAR_D0};
			end else if (c == tcce_pkg::CHAR_LEFT) begin
				if (cur_param <= {21'd0, cur_col})
					cur_col = cur_col - cur_param[tcce_pkg::ColBits-1:0];
				cur_esc = 1'b0;
			end else if (c != tcce_pkg::CHAR_LBRACKET) begin
				draw_at_cursor(c);
				cur_esc = 1'b0;
			end
		end
		if (cur_col >= {1'b0, cols_set}) begin
			cur_col = '0;
			row_advance();
			step_acc.inval = 1'b1;
		end
		if (cur_row >= rows_set) begin
			if (cur_row > 0)
				cur_row = cur_row - 1'b1;
			step_acc.scroll = step_acc.scroll + 1'b1;
			step_acc.inval = 1'b1;
		end
	endfunction

	function automatic console_result_t console_step(input logic [7:0] c);
		step_acc = '0;
		if (c == tcce_pkg::CHAR_LF)
			apply_char(tcce_pkg::CHAR_CR);
		apply_char(c);
		step_acc.ccol = cur_col[9:0];
		step_acc.crow = cur_row;
		return step_acc;
	endfunction

	function automatic void queue_sequence(input int lf_pct);
		int pick;
		int ndig;
		if ($urandom_range(99) < lf_pct) begin
			pending_codes.push_back(tcce_pkg::CHAR_LF);
			return;
		end
		pick = $urandom_range(99);
		if (pick < 35) begin
			pending_codes.push_back(tcce_pkg::CHAR_ESC);
			if ($urandom_range(1) == 1)
				pending_codes.push_back(tcce_pkg::CHAR_LBRACKET);
			ndig = ($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 3);
			for (int i = 0; i < ndig; i++)
				pending_codes.push_back(tcce_pkg::CHAR_D0 + 8'($urandom_range(9)));
			if ($urandom_range(99) < 60)
				pending_codes.push_back(tcce_pkg::CHAR_LEFT);
			else
				pending_codes.push_back(8'($urandom_range(255)));
		end else if (pick < 55) begin
			case ($urandom_range(3))
				0: pending_codes.push_back(tcce_pkg::CHAR_CR);
				1: pending_codes.push_back(tcce_pkg::CHAR_LF);
				2: pending_codes.push_back(tcce_pkg::CHAR_BS);
				default: pending_codes.push_back(tcce_pkg::CHAR_TAB);
			endcase
		end else if (pick < 90) begin
			pending_codes.push_back(8'($urandom_range(8'h20, 8'h7e)));
		end else begin
			pending_codes.push_back(8'($urandom_range(255)));
		end
	endfunction

	function automatic logic [7:0] next_code(input int lf_pct);
		if (pending_codes.size() == 0)
			queue_sequence(lf_pct);
		return pending_codes.pop_front();
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		error_count++;
		if (error_count <= 100)
			$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	task automatic check_result(input console_result_t want);
		if (draw_valid !== want.draw)
			report_mismatch("draw_valid", draw_valid, want.draw);
		if (glyph !== want.glyph)
			report_mismatch("glyph", glyph, want.glyph);
		if (draw_col !== want.dcol)
			report_mismatch("draw_col", draw_col, want.dcol);
		if (draw_row !== want.drow)
			report_mismatch("draw_row", draw_row, want.drow);
		if (scroll_lines !== want.scroll)
			report_mismatch("scroll_lines", scroll_lines, want.scroll);
		if (invalidate !== want.inval)
			report_mismatch("invalidate", invalidate, want.inval);
		if (cursor_col_out !== want.ccol)
			report_mismatch("cursor_col_out", cursor_col_out, want.ccol);
		if (cursor_row_out !== want.crow)
			report_mismatch("cursor_row_out", cursor_row_out, want.crow);
	endtask

	task automatic send_code(input logic [7:0] c, input logic known,
			input console_result_t want);
		int gap;
		console_result_t pred;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code <= c;
		do @(posedge clk); while (in_stall);
		pred = console_step(c);
		pending_results.push_back(known ? want : pred);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic start_phase(input logic [9:0] cols, input logic [9:0] rows,
			input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		cfg_valid <= 1'b1;
		cfg_index <= tcce_pkg::CFG_COLUMN_COUNT;
		cfg_data <= cols;
		do @(posedge clk); while (!cfg_ready);
		cols_set = cols;
		cfg_index <= tcce_pkg::CFG_ROW_COUNT;
		cfg_data <= rows;
		do @(posedge clk); while (!cfg_ready);
		rows_set = rows;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int n_items, input int lf_pct);
		for (int i = 0; i < n_items; i++)
			send_code(next_code(lf_pct), 1'b0, '0);
		pending_codes.delete();
		settle();
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected result item", 1, 0);
			else
				check_result(pending_results.pop_front());
		end
	end

	initial begin
		cur_col = '0;
		cur_row = '0;
		cur_esc = 1'b0;
		cur_param = '0;
		cols_set = tcce_pkg::COLUMN_COUNT_RESET;
		rows_set = tcce_pkg::ROW_COUNT_RESET;

		directed_rows.push_back('{8'h41, 1'b1,
			'{1'b1, 8'h41, 10'd0, 10'd0, 2'd0, 1'b0, 10'd1, 10'd0}});
		directed_rows.push_back('{8'hff, 1'b1,
			'{1'b1, 8'hff, 10'd1, 10'd0, 2'd0, 1'b0, 10'd2, 10'd0}});
		directed_rows.push_back('{8'h00, 1'b1,
			'{1'b1, 8'h00, 10'd2, 10'd0, 2'd0, 1'b0, 10'd3, 10'd0}});
		directed_rows.push_back('{tcce_pkg::CHAR_BS, 1'b1,
			'{1'b0, 8'h00, 10'd0, 10'd0, 2'd0, 1'b0, 10'd2, 10'd0}});
		directed_rows.push_back('{tcce_pkg::CHAR_TAB, 1'b1,
			'{1'b0, 8'h00, 10'd0, 10'd0, 2'd0, 1'b0, 10'd8, 10'd0}});
		directed_rows.push_back('{tcce_pkg::CHAR_CR, 1'b1,
			'{1'b0, 8'h00, 10'd0, 10'd0, 2'd0, 1'b0, 10'd0, 10'd0}});
		directed_rows.push_back('{tcce_pkg::CHAR_BS, 1'b1,
			'{1'b0, 8'h00, 10'd0, 10'd0, 2'd0, 1'b0, 10'd0, 10'd0}});
		directed_rows.push_back('{tcce_pkg::CHAR_LF, 1'b1,
			'{1'b0, 8'h00, 10'd0, 10'd0, 2'd0, 1'b1, 10'd0, 10'd1}});
		directed_rows.push_back('{tcce_pkg::CHAR_ESC, 1'b1,
			'{1'b0, 8'h00, 10'd0, 10'd0, 2'd0, 1'b0, 10'd0, 10'd1}});
		directed_rows.push_back('{tcce_pkg::CHAR_LBRACKET, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_D0 + 8'd5, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_LEFT, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_TAB, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_TAB, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_ESC, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_D0 + 8'd3, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_LEFT, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_ESC, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_LF, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_ESC, 1'b0, '0});
		directed_rows.push_back('{8'h51, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_ESC, 1'b0, '0});
		directed_rows.push_back('{tcce_pkg::CHAR_CR, 1'b0, '0});
		directed_rows.push_back('{8'h7f, 1'b0, '0});
		directed_rows.push_back('{8'h80, 1'b0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_code(directed_rows[i].c, directed_rows[i].known, directed_rows[i].want);
		settle();

		start_phase(10'd1, 10'd1, 65, 0);
		run_random(60, 10);
		start_phase(10'd0, 10'd0, 0, 65);
		run_random(60, 15);
		start_phase(10'd8, 10'd3, 6, 6);
		run_random(80, 10);
		start_phase(10'd1023, 10'd1023, 0, 0);
		run_random(60, 5);
		start_phase(10'd0, 10'd1023, 6, 6);
		run_random(40, 80);
		start_phase(10'd1023, 10'd2, 65, 0);
		run_random(60, 10);
		start_phase(10'($urandom_range(0, 40)), 10'($urandom_range(0, 30)), 0, 65);
		run_random(60, 10);
		start_phase(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)), 0, 0);
		run_random(60, 10);

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
